@@ sv/fsrp_pkg.sv @@
// Package for the folded sector ring position block.
// Holds the fixed sizes, derived widths, opcodes, the register address and the result type.
// It depends on nothing else.
package fsrp_pkg;

  localparam int MAX_SECTORS   = 16;
  localparam int COUNT_BITS    = 12;
  localparam int FRACTION_BITS = 16;

  localparam int IDX_W   = $clog2(MAX_SECTORS);
  localparam int SECT_W  = $clog2(MAX_SECTORS + 1);
  localparam int OFF_W   = COUNT_BITS + 1;
  localparam int RING_W  = COUNT_BITS + 2;
  localparam int TOTAL_W = COUNT_BITS + 1 + IDX_W;
  localparam int DEN_W   = RING_W + SECT_W;
  localparam int NUM_W   = DEN_W + 1;
  localparam int DVD_W   = NUM_W + FRACTION_BITS;
  localparam int CNT_W   = $clog2(DVD_W + 1);
  localparam int POS_W   = 16;
  localparam int CFG_W   = 5;
  localparam int PADDR_W = 3;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_RESTART = 2'd1;
  localparam logic [1:0] OP_ADVANCE = 2'd2;

  localparam logic [PADDR_W-1:0] ADDR_SECTOR_COUNT = 3'd0;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             is_folded;
    logic             last;
    logic             in_range;
  } result_t;

endpackage

@@ sv/folded_sector_ring_position.sv @@
// Top level of the folded sector ring position block: sector table, walk state,
// a bit-serial divider shared by both positions, and the APB register.
// Depends on fsrp_pkg.
//
// Channel   Direction  Handshake                 Payload
// cmd       in         cmd_valid / cmd_ready     opcode, entry_index, folded_count,
//                                                unfolded_count
// res       out        res_valid / res_ready     position, is_folded, last, in_range
// apb       in         psel, penable, pwrite     paddr, pwdata, prdata
//
// A write beat is taken while idle. An advance checks the walk on acceptance, steps over full
// sectors in the skip state and evaluates; then per position it passes a setup state, the
// divider states that shift out the quotient bit by bit and an output state, twice with the
// folded copy. A restart first sums the sectors in use and then goes on like an advance; an
// end beat goes from evaluation to output. Reset is synchronous, clears the walk state, sets
// the register to one, not the table. A stalled result holds the block in its output stage.
module folded_sector_ring_position
  import fsrp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  output logic                      cmd_ready,
  input  logic [1:0]                opcode,
  input  logic [IDX_W-1:0]          entry_index,
  input  logic [COUNT_BITS-1:0]     folded_count,
  input  logic [COUNT_BITS-1:0]     unfolded_count,
  output logic                      res_valid,
  input  logic                      res_ready,
  output logic [POS_W-1:0]          position,
  output logic                      is_folded,
  output logic                      last,
  output logic                      in_range,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_W-1:0]        paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SUM  = 3'd1;
  localparam logic [2:0] ST_SKIP = 3'd2;
  localparam logic [2:0] ST_EVAL = 3'd3;
  localparam logic [2:0] ST_PREP = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_PUT  = 3'd6;

  logic [COUNT_BITS-1:0] folded_table   [MAX_SECTORS];
  logic [COUNT_BITS-1:0] unfolded_table [MAX_SECTORS];

  logic [2:0]               state;
  logic [CFG_W-1:0]         sector_count;
  logic [SECT_W-1:0]        current_sector;
  logic [OFF_W-1:0]         offset_in_sector;
  logic [TOTAL_W-1:0]       ordinal_count;
  logic [TOTAL_W-1:0]       total_count;
  logic [DEN_W-1:0]         den;
  logic [DEN_W-1:0]         base;
  logic                     fold_pend;
  logic                     fold_cur;
  logic                     end_flag;
  logic [DEN_W-1:0]         rem;
  logic [DVD_W-1:0]         dvd;
  logic [POS_W-1:0]         quot;
  logic [CNT_W-1:0]         cnt;
  result_t                  res;

  logic [SECT_W-1:0]        n_use;
  logic [COUNT_BITS-1:0]    rd_f;
  logic [COUNT_BITS-1:0]    rd_u;
  logic [OFF_W-1:0]         rd_len;
  logic [RING_W-1:0]        r_calc;
  logic [NUM_W-1:0]         div_try;
  logic                     div_ge;
  logic [DEN_W-1:0]         rem_next;
  logic [NUM_W-1:0]         num_next;
  logic                     cmd_fire;
  logic                     out_free;
  logic                     cfg_write;

  assign cmd_ready = (state == ST_IDLE);
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign out_free  = !res_valid || res_ready;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[PADDR_W-1:2] == ADDR_SECTOR_COUNT[PADDR_W-1:2]) ?
                     32'(sector_count) : 32'd0;

  always_comb begin
    if (sector_count == '0) begin
      n_use = SECT_W'(1);
    end else if (32'(sector_count) > MAX_SECTORS) begin
      n_use = SECT_W'(MAX_SECTORS);
    end else begin
      n_use = SECT_W'(sector_count);
    end
  end

  assign rd_f   = folded_table[current_sector[IDX_W-1:0]];
  assign rd_u   = unfolded_table[current_sector[IDX_W-1:0]];
  assign rd_len = OFF_W'(rd_f) + OFF_W'(rd_u);
  assign r_calc = RING_W'({rd_f, 1'b0}) + RING_W'(rd_u);

  assign div_try  = {rem, dvd[DVD_W-1]};
  assign div_ge   = div_try >= {1'b0, den};
  assign rem_next = div_ge ? DEN_W'(div_try - {1'b0, den}) : DEN_W'(div_try);

  always_comb begin
    if (fold_pend) begin
      if (NUM_W'(base) >= NUM_W'(offset_in_sector)) begin
        num_next = NUM_W'(base) - NUM_W'(offset_in_sector);
      end else begin
        num_next = NUM_W'(base) + NUM_W'(den) - NUM_W'(offset_in_sector);
      end
    end else begin
      num_next = NUM_W'(base) + NUM_W'(offset_in_sector);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire && opcode == OP_WRITE) begin
      folded_table[entry_index]   <= folded_count;
      unfolded_table[entry_index] <= unfolded_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sector_count <= CFG_W'(1);
    end else if (cfg_write && paddr[PADDR_W-1:2] == ADDR_SECTOR_COUNT[PADDR_W-1:2]) begin
      sector_count <= pwdata[CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      current_sector   <= '0;
      offset_in_sector <= '0;
      ordinal_count    <= '0;
      total_count      <= '0;
      res_valid        <= 1'b0;
      fold_pend        <= 1'b0;
      fold_cur         <= 1'b0;
      end_flag         <= 1'b0;
    end else begin
      if (res_valid && res_ready && state != ST_PUT) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_fire) begin
            case (opcode)
              OP_RESTART: begin
                total_count    <= '0;
                current_sector <= '0;
                state          <= ST_SUM;
              end
              OP_ADVANCE: begin
                if (current_sector < n_use && ordinal_count < total_count) begin
                  ordinal_count    <= ordinal_count + TOTAL_W'(1);
                  offset_in_sector <= offset_in_sector + OFF_W'(1);
                  state            <= ST_SKIP;
                end else begin
                  state <= ST_EVAL;
                end
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_SUM: begin
          if (current_sector < n_use) begin
            total_count    <= total_count + TOTAL_W'(rd_len);
            current_sector <= current_sector + SECT_W'(1);
          end else begin
            current_sector   <= '0;
            offset_in_sector <= '0;
            ordinal_count    <= '0;
            state            <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          if (current_sector < n_use && offset_in_sector >= rd_len) begin
            current_sector   <= current_sector + SECT_W'(1);
            offset_in_sector <= '0;
          end else begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (current_sector >= n_use || ordinal_count >= total_count) begin
            end_flag <= 1'b1;
            state    <= ST_PUT;
          end else begin
            den       <= DEN_W'(r_calc) * DEN_W'(n_use);
            base      <= DEN_W'(current_sector[IDX_W-1:0]) * DEN_W'(r_calc);
            fold_pend <= OFF_W'(rd_f) > offset_in_sector;
            end_flag  <= (r_calc == '0);
            state     <= (r_calc == '0) ? ST_PUT : ST_PREP;
          end
        end
        ST_PREP: begin
          fold_cur <= fold_pend;
          rem      <= '0;
          dvd      <= {num_next, FRACTION_BITS'(0)};
          cnt      <= CNT_W'(DVD_W);
          state    <= ST_DIV;
        end
        ST_DIV: begin
          rem  <= rem_next;
          dvd  <= {dvd[DVD_W-2:0], 1'b0};
          quot <= {quot[POS_W-2:0], div_ge};
          cnt  <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            state <= ST_PUT;
          end
        end
        ST_PUT: begin
          if (out_free) begin
            res_valid <= 1'b1;
            if (end_flag) begin
              res      <= '{position: '0, is_folded: 1'b0, last: 1'b1, in_range: 1'b0};
              end_flag <= 1'b0;
              state    <= ST_IDLE;
            end else begin
              res <= '{position: quot, is_folded: fold_cur, last: !fold_cur,
                       in_range: 1'b1};
              if (fold_cur) begin
                fold_pend <= 1'b0;
                state     <= ST_PREP;
              end else begin
                state <= ST_IDLE;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign position  = res.position;
  assign is_folded = res.is_folded;
  assign last      = res.last;
  assign in_range  = res.in_range;

  a_folded_not_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && is_folded |-> !last && in_range)
    else $error("A folded beat is marked last or out of range.");

  a_end_beat_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && !in_range |-> position == '0 && last && !is_folded)
    else $error("An end beat carries a position.");

  a_div_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> den != '0 && rem < den)
    else $error("The divider runs with a bad divisor or remainder.");

  a_sector_bound: assert property (@(posedge clk) disable iff (rst)
    32'(current_sector) <= MAX_SECTORS)
    else $error("The walk ran past the sector table.");

  a_put_blocks_cmd: assert property (@(posedge clk) disable iff (rst)
    state == ST_PUT && !out_free |=> state == ST_PUT && !cmd_ready)
    else $error("A pending result was dropped while the output stalled.");

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for folded_sector_ring_position: directed and random beats with
// an internal predictor of the sector walk and of the forward and folded ring positions.
// Depends on fsrp_pkg and on the RTL of the block.
`timescale 1ns / 100ps

module testbench;
  import fsrp_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int COUNT_MAX = (1 << COUNT_BITS) - 1;
  localparam int SETTLE_CYCLES = 150;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst;
  logic cmd_valid;
  logic cmd_ready;
  logic [1:0] opcode;
  logic [IDX_W-1:0] entry_index;
  logic [COUNT_BITS-1:0] folded_count;
  logic [COUNT_BITS-1:0] unfolded_count;
  logic res_valid;
  logic res_ready;
  logic [POS_W-1:0] position;
  logic is_folded;
  logic last;
  logic in_range;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  folded_sector_ring_position i_dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .opcode(opcode),
    .entry_index(entry_index),
    .folded_count(folded_count),
    .unfolded_count(unfolded_count),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .position(position),
    .is_folded(is_folded),
    .last(last),
    .in_range(in_range),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [COUNT_BITS-1:0] fold_tab [MAX_SECTORS];
  logic [COUNT_BITS-1:0] unfold_tab [MAX_SECTORS];
  logic [CFG_W-1:0] sector_reg = CFG_W'(1);
  logic [SECT_W-1:0] walk_sector = '0;
  logic [OFF_W-1:0] walk_offset = '0;
  logic [TOTAL_W-1:0] walk_ordinal = '0;
  logic [TOTAL_W-1:0] walk_total = '0;
  result_t ring_expected[$];

  int unsigned mismatch_count = 0;
  int unsigned gap_pct = 15;
  int unsigned stall_pct = 3;
  bit full_rate = 1'b0;

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%s", msg);
    end
  endtask

  function automatic int unsigned sectors_used();
    if (sector_reg == 0) return 1;
    if (sector_reg > MAX_SECTORS) return MAX_SECTORS;
    return int'(sector_reg);
  endfunction

  function automatic int unsigned sector_len(input int unsigned s);
    return int'(fold_tab[s]) + int'(unfold_tab[s]);
  endfunction

  function automatic void push_position(input logic [POS_W-1:0] pos, input bit folded,
                                        input bit fin, input bit inr);
    result_t r;
    r.position = pos;
    r.is_folded = folded;
    r.last = fin;
    r.in_range = inr;
    ring_expected = {ring_expected, r};
  endfunction

  function automatic void skip_full_sectors(input int unsigned n);
    while (walk_sector < n && walk_offset >= sector_len(walk_sector)) begin
      walk_sector++;
      walk_offset = '0;
    end
  endfunction

  function automatic void emit_ring_positions();
    int unsigned n;
    logic [RING_W-1:0] ring;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] base;
    n = sectors_used();
    if (walk_sector >= n || walk_ordinal >= walk_total) begin
      push_position('0, 1'b0, 1'b1, 1'b0);
      return;
    end
    ring = RING_W'(2 * fold_tab[walk_sector] + unfold_tab[walk_sector]);
    if (ring == 0) begin
      push_position('0, 1'b0, 1'b1, 1'b0);
      return;
    end
    den = 64'(ring) * 64'(n);
    base = 64'(walk_sector) * 64'(ring);
    if (walk_offset < fold_tab[walk_sector]) begin
      if (base >= 64'(walk_offset)) begin
        num = base - 64'(walk_offset);
      end else begin
        num = base + den - 64'(walk_offset);
      end
      push_position(POS_W'((num << FRACTION_BITS) / den), 1'b1, 1'b0, 1'b1);
    end
    num = base + 64'(walk_offset);
    push_position(POS_W'((num << FRACTION_BITS) / den), 1'b0, 1'b1, 1'b1);
  endfunction

  function automatic void predict_ring_beat(input logic [1:0] op,
                                            input logic [IDX_W-1:0] idx,
                                            input logic [COUNT_BITS-1:0] fcount,
                                            input logic [COUNT_BITS-1:0] ucount);
    int unsigned n;
    int unsigned sum;
    n = sectors_used();
    case (op)
      OP_WRITE: begin
        fold_tab[idx] = fcount;
        unfold_tab[idx] = ucount;
      end
      OP_RESTART: begin
        sum = 0;
        for (int unsigned i = 0; i < n; i++) begin
          sum += sector_len(i);
        end
        walk_total = TOTAL_W'(sum);
        walk_ordinal = '0;
        walk_sector = '0;
        walk_offset = '0;
        skip_full_sectors(n);
        emit_ring_positions();
      end
      OP_ADVANCE: begin
        if (walk_sector < n && walk_ordinal < walk_total) begin
          walk_ordinal++;
          walk_offset++;
          skip_full_sectors(n);
        end
        emit_ring_positions();
      end
      default: begin
      end
    endcase
  endfunction

  // One beat on the command channel; the prediction is made at the accepting edge.
  task automatic send_beat(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [COUNT_BITS-1:0] fcount,
                           input logic [COUNT_BITS-1:0] ucount);
    if (!full_rate && $urandom_range(99, 0) < gap_pct) begin
      @(negedge clk) cmd_valid <= 1'b0;
      repeat ($urandom_range(18, 1) - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd_valid <= 1'b1;
    opcode <= op;
    entry_index <= idx;
    folded_count <= fcount;
    unfolded_count <= ucount;
    do @(posedge clk); while (cmd_ready !== 1'b1);
    predict_ring_beat(op, idx, fcount, ucount);
  endtask

  task automatic send_random_payload(input logic [1:0] op);
    send_beat(op, IDX_W'($urandom()), COUNT_BITS'($urandom()), COUNT_BITS'($urandom()));
  endtask

  task automatic drain_results();
    @(negedge clk) cmd_valid <= 1'b0;
    while (ring_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_sector_count();
    logic [31:0] rdata;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_SECTOR_COUNT;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (rdata !== 32'(sector_reg)) begin
      flag_mismatch($sformatf("sector_count read: expected %0d, got %0d", sector_reg, rdata));
    end
  endtask

  task automatic set_sector_count(input logic [CFG_W-1:0] count);
    logic [31:0] wdata;
    wdata = {(32 - CFG_W)'($urandom()), count};
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_SECTOR_COUNT;
    pwdata <= wdata;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sector_reg = count;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    check_sector_count();
  endtask

  function automatic logic [COUNT_BITS-1:0] pick_count();
    case ($urandom_range(15, 0))
      0: return COUNT_BITS'($urandom_range(COUNT_MAX, 0));
      1: return COUNT_BITS'(COUNT_MAX);
      2, 3, 4: return '0;
      default: return COUNT_BITS'($urandom_range(3, 1));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_sector_count();
    case ($urandom_range(7, 0))
      0: return CFG_W'(0);
      1: return CFG_W'(1);
      2: return CFG_W'(MAX_SECTORS);
      3: return CFG_W'(MAX_SECTORS + 1);
      4: return CFG_W'((1 << CFG_W) - 1);
      default: return CFG_W'($urandom_range(MAX_SECTORS, 2));
    endcase
  endfunction

  task automatic write_random_entry();
    if ($urandom_range(7, 0) == 0) begin
      send_beat(OP_WRITE, IDX_W'($urandom()), '0, '0);
    end else begin
      send_beat(OP_WRITE, IDX_W'($urandom()), pick_count(), pick_count());
    end
  endtask

  task automatic test_reset_state();
    check_sector_count();
    send_beat(OP_ADVANCE, '0, '0, '0);
    send_beat(OP_UNUSED, '1, '1, '1);
    drain_results();
  endtask

  // Leading and middle empty sectors, a folded stretch, then one beat past the end.
  task automatic test_short_walk();
    send_beat(OP_WRITE, 4'd0, '0, '0);
    send_beat(OP_WRITE, 4'd1, 12'd2, 12'd1);
    send_beat(OP_WRITE, 4'd2, '0, '0);
    send_beat(OP_WRITE, 4'd3, 12'd1, 12'd2);
    drain_results();
    set_sector_count(CFG_W'(4));
    send_beat(OP_RESTART, '0, '0, '0);
    repeat (6) send_beat(OP_ADVANCE, '0, '0, '0);
    drain_results();
  endtask

  task automatic test_count_extremes();
    send_beat(OP_WRITE, 4'd0, COUNT_BITS'(COUNT_MAX), COUNT_BITS'(COUNT_MAX));
    for (int i = 4; i < MAX_SECTORS - 1; i++) begin
      if (i % 2 == 1) begin
        send_beat(OP_WRITE, IDX_W'(i), COUNT_BITS'(COUNT_MAX), '0);
      end else begin
        send_beat(OP_WRITE, IDX_W'(i), '0, COUNT_BITS'(COUNT_MAX));
      end
    end
    send_beat(OP_WRITE, IDX_W'(MAX_SECTORS - 1), COUNT_BITS'(COUNT_MAX),
              COUNT_BITS'(COUNT_MAX));
    drain_results();
    set_sector_count(CFG_W'((1 << CFG_W) - 1));
    send_beat(OP_RESTART, '1, '1, '1);
    repeat (2) send_beat(OP_ADVANCE, '1, '1, '1);
    drain_results();
  endtask

  task automatic test_random_walks(input int unsigned beats);
    int unsigned done;
    int unsigned steps;
    int unsigned pick;
    logic [1:0] op;
    done = 0;
    while (done < beats) begin
      drain_results();
      case ($urandom_range(2, 0))
        0: gap_pct = 0;
        1: gap_pct = 15;
        default: gap_pct = 50;
      endcase
      case ($urandom_range(2, 0))
        0: stall_pct = 0;
        1: stall_pct = 3;
        default: stall_pct = 12;
      endcase
      set_sector_count(pick_sector_count());
      repeat ($urandom_range(5, 1)) begin
        write_random_entry();
        done++;
      end
      send_random_payload(OP_RESTART);
      done++;
      steps = (walk_total + 2 > 60) ? 60 : walk_total + 2;
      repeat (steps) begin
        pick = $urandom_range(99, 0);
        if (pick < 5) begin
          send_random_payload(OP_UNUSED);
        end else begin
          if (pick < 9) begin
            write_random_entry();
          end else if (pick < 11) begin
            send_random_payload(OP_RESTART);
          end else if (pick < 14) begin
            op = 2'($urandom_range(2, 0));
            send_random_payload(op);
          end else begin
            send_random_payload(OP_ADVANCE);
          end
          done++;
        end
      end
    end
  endtask

  task automatic test_back_to_back();
    full_rate = 1'b1;
    test_random_walks(100);
  endtask

  initial begin
    res_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (!full_rate && $urandom_range(99, 0) < stall_pct) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(18, 1)) @(negedge clk);
      end
      res_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && res_valid === 1'b1 && res_ready) begin
      if (ring_expected.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat: position %0d is_folded %0b last %0b %s %0b",
                                position, is_folded, last, "in_range", in_range));
      end else begin
        want = ring_expected.pop_front();
        if (position !== want.position) begin
          flag_mismatch($sformatf("position: expected %0d, got %0d", want.position, position));
        end
        if (is_folded !== want.is_folded) begin
          flag_mismatch($sformatf("is_folded: expected %0b, got %0b", want.is_folded, is_folded));
        end
        if (last !== want.last) begin
          flag_mismatch($sformatf("last: expected %0b, got %0b", want.last, last));
        end
        if (in_range !== want.in_range) begin
          flag_mismatch($sformatf("in_range: expected %0b, got %0b", want.in_range, in_range));
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((cmd_valid && cmd_ready) || (res_valid && res_ready) || (psel && penable && pready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    for (int i = 0; i < MAX_SECTORS; i++) begin
      fold_tab[i] = '0;
      unfold_tab[i] = '0;
    end
    rst = 1'b1;
    cmd_valid = 1'b0;
    opcode = OP_WRITE;
    entry_index = '0;
    folded_count = '0;
    unfolded_count = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = ADDR_SECTOR_COUNT;
    pwdata = '0;
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_reset_state();
    test_short_walk();
    test_count_extremes();
    test_random_walks(1000);
    test_back_to_back();
    drain_results();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/fsrp_pkg.sv
sv/folded_sector_ring_position.sv
tb/sv/testbench.sv
